FILE: hdl/sipd_pkg.sv
// ----------------------------------------------------------------------------
// sipd_pkg: shared types and constants for the decimal text converter
// Character codes, stream payload widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package sipd_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    // bcd digit width and the threshold for the add-3 correction
    localparam int         BCD_W      = 4;
    localparam logic [3:0] BCD_ADJ_GE = 4'd5;
    localparam logic [3:0] BCD_ADJ    = 4'd3;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CONV  = 4'b0010,
        ST_SETUP = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

FILE: hdl/signed_int_to_padded_decimal.sv
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal: signed integer to blank-padded ascii decimal
// Converts a two's complement value by shift-and-add-3 on a shared bcd unit,
// then streams blanks, an optional minus and the digits, msb character first.
// ----------------------------------------------------------------------------
// sequence: an input transfer starts the bcd shifting, then a setup state
//   sets the run length before the first character; then one character per
//   cycle while m_tready is high. Each run is max(min(min_width, MAX_WIDTH),
//   text length) characters; a new item is taken only in idle, after the
//   last character of the previous run, as there is a single bcd shift unit
// reset: aresetn, synchronous active low, returns the sequencer to idle
module signed_int_to_padded_decimal
    import sipd_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata fields from bit 0: value[31:0], min_width[38:32]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata fields from bit 0: character[7:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    // digits needed for 2^VALUE_BITS - 1 (1233/4096 approximates log10 2)
    localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int NDIG_W     = $clog2(NUM_DIGITS + 1);
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int REM_W      = $clog2(MAX_WIDTH);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int BCD_TOT_W  = NUM_DIGITS * BCD_W;
    localparam int MIN_W_LSB  = 32;
    localparam int MIN_W_W    = 7;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic [BCD_TOT_W-1:0]   bcd_reg, bcd_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       width_reg, width_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic [REM_W-1:0]       rem_reg, rem_next;

    logic [VALUE_BITS-1:0]  raw;
    logic [MIN_W_W-1:0]     min_width;
    logic [BCD_TOT_W-1:0]   bcd_adj;
    logic [NDIG_W-1:0]      ndig_found;
    logic [CNT_W-1:0]       text_len;
    logic [CNT_W-1:0]       total;
    logic [CNT_W-1:0]       rem_ext;
    logic [CNT_W-1:0]       ndig_ext;
    logic [BCD_W-1:0]       cur_digit;

    assign raw       = s_tdata[VALUE_BITS-1:0];
    assign min_width = s_tdata[MIN_W_LSB +: MIN_W_W];

    // add-3 correction on every digit before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*BCD_W +: BCD_W] >= BCD_ADJ_GE) begin
                bcd_adj[i*BCD_W +: BCD_W] = bcd_reg[i*BCD_W +: BCD_W] + BCD_ADJ;
            end else begin
                bcd_adj[i*BCD_W +: BCD_W] = bcd_reg[i*BCD_W +: BCD_W];
            end
        end
    end

    // count of significant digits, at least one
    always_comb begin
        ndig_found = NDIG_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (bcd_reg[i*BCD_W +: BCD_W] != '0) begin
                ndig_found = NDIG_W'(i + 1);
            end
        end
    end

    assign text_len = CNT_W'(ndig_found) + CNT_W'(neg_reg);
    assign total    = (width_reg > text_len) ? width_reg : text_len;

    // character at the current position, counted from the right end
    assign rem_ext   = CNT_W'(rem_reg);
    assign ndig_ext  = CNT_W'(ndig_reg);
    assign cur_digit = bcd_reg[rem_reg[DIG_IDX_W-1:0]*BCD_W +: BCD_W];

    always_comb begin
        if (rem_ext < ndig_ext) begin
            m_tdata = CH_ZERO + {4'b0000, cur_digit};
        end else if (neg_reg && (rem_ext == ndig_ext)) begin
            m_tdata = CH_MINUS;
        end else begin
            m_tdata = CH_BLANK;
        end
    end

    assign m_tlast  = (rem_reg == '0);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        neg_next     = neg_reg;
        width_next   = width_reg;
        ndig_next    = ndig_reg;
        rem_next     = rem_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_W'(VALUE_BITS - 1);
                    if (MIN_W_W'(min_width) > MIN_W_W'(MAX_WIDTH)) begin
                        width_next = CNT_W'(MAX_WIDTH);
                    end else begin
                        width_next = min_width[CNT_W-1:0];
                    end
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = {bcd_adj[BCD_TOT_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                ndig_next  = ndig_found;
                rem_next   = REM_W'(total - 1'b1);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (rem_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rem_next = rem_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        neg_reg     <= neg_next;
        width_reg   <= width_next;
        ndig_reg    <= ndig_next;
        rem_reg     <= rem_next;
    end

endmodule

FILE: hdl/sipd_checker.sv
// ----------------------------------------------------------------------------
// sipd_checker: port-level checks for the decimal text converter
// Watches both stream channels and the sequencing between them.
// ----------------------------------------------------------------------------
module sipd_checker
    import sipd_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // one item at a time: never ready for input while emitting
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while characters are pending");

    // conversion takes cycles after an input transfer
    a_conv_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("character shown right after input transfer");

    // a run continues until its last character
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("run ended without last");

    // after the last character the block is ready for the next item
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("not idle after last character");

    // stalled output holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output changed");

endmodule

bind signed_int_to_padded_decimal sipd_checker u_sipd_checker (.*);
